FILE: rtl/core/display_frame_checker_macros.svh
// Assertion macros shared by the display frame checker RTL.
`ifndef DISPLAY_FRAME_CHECKER_MACROS_SVH
`define DISPLAY_FRAME_CHECKER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DFC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("display frame checker: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define DFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("display frame checker: next-cycle check failed");

`endif

FILE: rtl/core/dfc_pkg.sv
// Types and constants shared by the display frame checker modules.
package dfc_pkg;

   // default sizes
   localparam int BUFFER_LEN_DEF = 128;
   localparam int LINE_LEN_DEF   = 16;

   // frame layout
   localparam int ADDR_AT   = 3;
   localparam int LINE0_AT  = 25;
   localparam int LINE1_AT  = 43;
   localparam int CURSOR_AT = 79;

   // character codes and arithmetic constants
   localparam logic [7:0] STAR_CH   = 8'd42;
   localparam logic [7:0] ZERO_CH   = 8'd48;
   localparam logic [7:0] ACTIVE_CH = 8'd65;
   localparam logic [7:0] TEN       = 8'd10;

   // signed width of the address value: (255-48)*10 + 207 fits in 13 bits
   localparam int ADDR_W = 13;

   // result stream packing
   localparam int COL_W   = 4;
   localparam int RDATA_W = 32;

   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_CURSOR   = 2'd1,
      KIND_MISMATCH = 2'd2,
      KIND_IGNORED  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CHAR,
      PH_FINAL
   } phase_type;

   // frame judgment handed from the accumulator to the emitter
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] cursor_row;
      logic [7:0] cursor_col;
      logic       cursor_on;
   } verdict_type;

   // one result item
   typedef struct packed {
      kind_type         kind;
      logic             line;
      logic [COL_W-1:0] column;
      logic [7:0]       character;
      logic [7:0]       cursor_row;
      logic [7:0]       cursor_col;
      logic             cursor_on;
      logic             last;
   } result_type;

endpackage

FILE: rtl/core/dfc_accum.sv
// Frame accumulator: position, checksum, parsed check value, captures and judgment.
module dfc_accum #(
   parameter int BUFFER_LEN = dfc_pkg::BUFFER_LEN_DEF,
   parameter int LINE_LEN   = dfc_pkg::LINE_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [7:0]                    rx_byte,
   input  logic                          frame_last,
   output dfc_pkg::verdict_type          verdict,
   output logic [2*LINE_LEN-1:0][7:0]    line_snap
);
   import dfc_pkg::*;

   localparam int NCHAR = 2 * LINE_LEN;
   localparam logic [7:0] BUF_END = 8'(BUFFER_LEN);

   logic [7:0]            position_ff, position_in, upd_position;
   logic [7:0]            sum_ff, sum_in, upd_sum;
   logic                  star_ff, star_in, upd_star;
   logic [7:0]            parsed_ff, parsed_in, upd_parsed;
   logic [1:0][7:0]       addr_ff, addr_in, upd_addr;
   logic [NCHAR-1:0][7:0] line_ff, line_in, upd_line;
   logic [3:0][7:0]       cursor_ff, cursor_in, upd_cursor;

   logic signed [ADDR_W-1:0] addr_hi, addr_lo, addr_val;
   logic                     broadcast;
   logic                     frame_end;

   // apply the current byte to the frame state
   always_comb begin
      upd_position = position_ff;
      upd_sum      = sum_ff;
      upd_star     = star_ff;
      upd_parsed   = parsed_ff;
      upd_addr     = addr_ff;
      upd_line     = line_ff;
      upd_cursor   = cursor_ff;
      if (position_ff < BUF_END) begin
         if (!star_ff) begin
            upd_sum = sum_ff + rx_byte;
            if (rx_byte == STAR_CH) begin
               upd_star = 1'b1;
            end
         end else begin
            upd_parsed = parsed_ff * TEN + rx_byte - ZERO_CH;
         end
         for (int i = 0; i < 2; i++) begin
            if (position_ff == 8'(ADDR_AT + i)) begin
               upd_addr[i] = rx_byte;
            end
         end
         for (int i = 0; i < LINE_LEN; i++) begin
            if (position_ff == 8'(LINE0_AT + i)) begin
               upd_line[i] = rx_byte;
            end
            if (position_ff == 8'(LINE1_AT + i)) begin
               upd_line[LINE_LEN + i] = rx_byte;
            end
         end
         for (int i = 0; i < 4; i++) begin
            if (position_ff == 8'(CURSOR_AT + i)) begin
               upd_cursor[i] = rx_byte;
            end
         end
         upd_position = position_ff + 8'd1;
      end
   end

   // judge the frame on its final byte
   always_comb begin
      addr_hi   = $signed({{(ADDR_W-8){1'b0}}, upd_addr[0]}) - $signed(ADDR_W'(48));
      addr_lo   = $signed({{(ADDR_W-8){1'b0}}, upd_addr[1]}) - $signed(ADDR_W'(48));
      addr_val  = addr_hi * $signed(ADDR_W'(10)) + addr_lo;
      broadcast = (addr_val == '0);
      frame_end = take && frame_last;

      verdict.valid      = frame_end;
      verdict.cursor_row = 8'd0;
      verdict.cursor_col = 8'd0;
      verdict.cursor_on  = 1'b0;
      if (!broadcast || !upd_star) begin
         verdict.kind = KIND_IGNORED;
      end else if (upd_sum != upd_parsed) begin
         verdict.kind = KIND_MISMATCH;
      end else begin
         verdict.kind       = KIND_CURSOR;
         verdict.cursor_row = upd_cursor[0] - ZERO_CH;
         verdict.cursor_col = (upd_cursor[1] - ZERO_CH) * TEN + upd_cursor[2] - ZERO_CH;
         verdict.cursor_on  = (upd_cursor[3] == ACTIVE_CH);
      end
      line_snap = upd_line;
   end

   // select next register values; a frame end clears the running state
   always_comb begin
      position_in = position_ff;
      sum_in      = sum_ff;
      star_in     = star_ff;
      parsed_in   = parsed_ff;
      addr_in     = addr_ff;
      line_in     = line_ff;
      cursor_in   = cursor_ff;
      if (take) begin
         addr_in   = upd_addr;
         line_in   = upd_line;
         cursor_in = upd_cursor;
         if (frame_last) begin
            position_in = 8'd0;
            sum_in      = 8'd0;
            star_in     = 1'b0;
            parsed_in   = 8'd0;
         end else begin
            position_in = upd_position;
            sum_in      = upd_sum;
            star_in     = upd_star;
            parsed_in   = upd_parsed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         sum_ff      <= '0;
         star_ff     <= 1'b0;
         parsed_ff   <= '0;
         addr_ff     <= '0;
         line_ff     <= '0;
         cursor_ff   <= '0;
      end else begin
         position_ff <= position_in;
         sum_ff      <= sum_in;
         star_ff     <= star_in;
         parsed_ff   <= parsed_in;
         addr_ff     <= addr_in;
         line_ff     <= line_in;
         cursor_ff   <= cursor_in;
      end
   end

endmodule

FILE: rtl/core/dfc_emit.sv
// Result sequencer: holds a judged frame and streams its result items.
module dfc_emit #(
   parameter int LINE_LEN = dfc_pkg::LINE_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dfc_pkg::verdict_type       verdict,
   input  logic [2*LINE_LEN-1:0][7:0] line_snap,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output dfc_pkg::result_type        result
);
   import dfc_pkg::*;

   localparam int NCHAR = 2 * LINE_LEN;
   localparam int IDX_W = $clog2(NCHAR);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NCHAR - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_LEN - 1);

   phase_type             phase_ff, phase_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  line_ff, line_in;
   logic [NCHAR-1:0][7:0] snap_ff;
   kind_type              kind_ff;
   logic [7:0]            row_ff, ccol_ff;
   logic                  on_ff;

   // next phase, counters and the result item
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      col_in   = col_ff;
      line_in  = line_ff;
      result   = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (verdict.valid) begin
               phase_in = (verdict.kind == KIND_CURSOR) ? PH_CHAR : PH_FINAL;
               idx_in   = '0;
               col_in   = '0;
               line_in  = 1'b0;
            end
         end
         PH_CHAR: begin
            result.kind      = KIND_CHAR;
            result.line      = line_ff;
            result.column    = col_ff;
            result.character = snap_ff[idx_ff];
            if (rsp_ready) begin
               if (idx_ff == IDX_LAST) begin
                  phase_in = PH_FINAL;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
               if (col_ff == COL_LAST) begin
                  col_in  = '0;
                  line_in = 1'b1;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         PH_FINAL: begin
            result.kind       = kind_ff;
            result.cursor_row = row_ff;
            result.cursor_col = ccol_ff;
            result.cursor_on  = on_ff;
            result.last       = 1'b1;
            if (rsp_ready) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      rsp_valid = (phase_ff != PH_IDLE);
   end

   // phase and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         col_ff   <= '0;
         line_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
      end
   end

   // capture the frame snapshot and its verdict
   always_ff @(posedge clock) begin
      if (verdict.valid && phase_ff == PH_IDLE) begin
         snap_ff <= line_snap;
         kind_ff <= verdict.kind;
         row_ff  <= verdict.cursor_row;
         ccol_ff <= verdict.cursor_col;
         on_ff   <= verdict.cursor_on;
      end
   end

endmodule

FILE: rtl/core/display_frame_checker.sv
// Display frame checker: one frame byte per cycle in, judged frame results out.
// The first result of a frame is valid in the cycle after its final byte is taken.
// One byte per cycle; a good frame gives 2*LINE_LEN+1 results, one per cycle while rsp_tready is high.
// A final byte is held off while the previous frame's results are still being sent.
// Reset (synchronous) clears all frame state, captured bytes and the result sequencer.
`include "display_frame_checker_macros.svh"

module display_frame_checker #(
   parameter int BUFFER_LEN = dfc_pkg::BUFFER_LEN_DEF,
   parameter int LINE_LEN   = dfc_pkg::LINE_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // input byte stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] rx_byte
   input  logic                        req_tlast,   // frame_last
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] line, [4:1] column, [12:5] character, [20:13] cursor_row,
   // [28:21] cursor_col, [29] cursor_on, [31:30] zero
   output logic [dfc_pkg::RDATA_W-1:0] rsp_tdata,
   output logic [1:0]                  rsp_tuser,   // [1:0] kind
   output logic                        rsp_tlast    // last
);
   import dfc_pkg::*;

   localparam int NCHAR = 2 * LINE_LEN;
   localparam int PAD_W = RDATA_W - (1 + COL_W + 8 + 8 + 8 + 1);

   logic                  take;
   verdict_type           verdict;
   logic [NCHAR-1:0][7:0] line_snap;
   result_type            result;

   // hold off a final byte while results are still being sent
   assign req_tready = !(rsp_tvalid && req_tlast);
   assign take       = req_tvalid && req_tready;

   dfc_accum #(
      .BUFFER_LEN (BUFFER_LEN),
      .LINE_LEN   (LINE_LEN)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_tdata),
      .frame_last (req_tlast),
      .verdict    (verdict),
      .line_snap  (line_snap)
   );

   dfc_emit #(
      .LINE_LEN (LINE_LEN)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .verdict   (verdict),
      .line_snap (line_snap),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .result    (result)
   );

   // pack the result item
   assign rsp_tdata = {{PAD_W{1'b0}}, result.cursor_on, result.cursor_col,
                       result.cursor_row, result.character, result.column, result.line};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

   // a final byte is never taken while a frame's results are pending
   `DFC_ASSERT_SAME(a_last_held, clock, reset, rsp_tvalid && req_tlast, !req_tready)
   // a taken final byte starts its results in the next cycle
   `DFC_ASSERT_NEXT(a_frame_starts, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid)
   // the final result of a frame leaves the result stream empty
   `DFC_ASSERT_NEXT(a_frame_done, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)

endmodule

FILE: sim/tb_top.sv
// Testbench for display_frame_checker: random byte frames in, predicted display items checked out.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dfc_pkg::*;

   localparam int BUF_LEN     = BUFFER_LEN_DEF;
   localparam int LINE_CHARS  = LINE_LEN_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;

   typedef enum {
      FLAW_NONE,
      FLAW_ADDR,
      FLAW_NOSTAR,
      FLAW_SUM,
      FLAW_NOISE
   } frame_flaw_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // stimulus control shared with the receiver process
   bit src_idle_on      = 1'b1;
   bit sink_idle_on     = 1'b1;
   int sink_hold_cycles = 0;
   int items_sent       = 0;
   int mismatch_count   = 0;
   int cycle_count      = 0;

   // frame under construction
   logic [7:0] frame_bytes [$];

   // predictor state
   int         frame_pos = 0;
   logic [7:0] sum_acc   = '0;
   logic [7:0] check_acc = '0;
   logic       star_flag = 1'b0;
   logic [7:0] addr_cap   [2]            = '{default: '0};
   logic [7:0] line_cap   [2*LINE_CHARS] = '{default: '0};
   logic [7:0] cursor_cap [4]            = '{default: '0};
   result_type display_items_due [$];

   string item_field [8] = '{"kind", "line", "column", "character",
                             "cursor_row", "cursor_col", "cursor_on", "last"};

   display_frame_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Take one byte into the predicted state; judge the frame on its final byte.
   task automatic predict_frame_byte(input logic [7:0] b, input logic fin);
      int         addr_value;
      result_type r;
      if (frame_pos < BUF_LEN) begin
         if (!star_flag) begin
            sum_acc = sum_acc + b;
            if (b == STAR_CH) star_flag = 1'b1;
         end else begin
            check_acc = check_acc * TEN + b - ZERO_CH;
         end
         if (frame_pos >= ADDR_AT && frame_pos < ADDR_AT + 2)
            addr_cap[frame_pos - ADDR_AT] = b;
         if (frame_pos >= LINE0_AT && frame_pos < LINE0_AT + LINE_CHARS)
            line_cap[frame_pos - LINE0_AT] = b;
         if (frame_pos >= LINE1_AT && frame_pos < LINE1_AT + LINE_CHARS)
            line_cap[LINE_CHARS + frame_pos - LINE1_AT] = b;
         if (frame_pos >= CURSOR_AT && frame_pos < CURSOR_AT + 4)
            cursor_cap[frame_pos - CURSOR_AT] = b;
         frame_pos++;
      end
      if (fin) begin
         // address is a true integer, so only exact broadcast passes
         addr_value = (int'(addr_cap[0]) - int'(ZERO_CH)) * int'(TEN)
                      + int'(addr_cap[1]) - int'(ZERO_CH);
         r = '0;
         r.last = 1'b1;
         if (addr_value != 0 || !star_flag) begin
            r.kind = KIND_IGNORED;
            display_items_due.push_back(r);
         end else if (sum_acc != check_acc) begin
            r.kind = KIND_MISMATCH;
            display_items_due.push_back(r);
         end else begin
            for (int i = 0; i < 2 * LINE_CHARS; i++) begin
               r = '0;
               r.kind      = KIND_CHAR;
               r.line      = 1'(i / LINE_CHARS);
               r.column    = 4'(i % LINE_CHARS);
               r.character = line_cap[i];
               display_items_due.push_back(r);
            end
            r = '0;
            r.kind       = KIND_CURSOR;
            r.cursor_row = cursor_cap[0] - ZERO_CH;
            r.cursor_col = (cursor_cap[1] - ZERO_CH) * TEN + cursor_cap[2] - ZERO_CH;
            r.cursor_on  = (cursor_cap[3] == ACTIVE_CH);
            r.last       = 1'b1;
            display_items_due.push_back(r);
         end
         // clear per-frame state, keep captured bytes
         frame_pos = 0;
         sum_acc   = '0;
         check_acc = '0;
         star_flag = 1'b0;
      end
   endtask

   // Offer one byte after an optional idle burst; hold it until accepted.
   task automatic send_frame_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            req_tdata  = 8'($urandom);
            req_tlast  = 1'($urandom);
         end
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = fin;
      do @(posedge clock); while (!req_tready);
      predict_frame_byte(b, fin);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i])
         send_frame_byte(frame_bytes[i], 1'(i == frame_bytes.size() - 1));
   endtask

   // Drop valid and wait until every predicted item has arrived.
   task automatic wait_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (display_items_due.size() != 0) @(posedge clock);
   endtask

   // Set the byte at p so that the folded value after the star matches the sum.
   function automatic void close_checksum(input int star_at, input int p);
      logic [7:0] sum_part;
      logic [7:0] fold_part;
      sum_part  = '0;
      fold_part = '0;
      for (int i = 0; i <= star_at; i++) sum_part = sum_part + frame_bytes[i];
      for (int i = star_at + 1; i < p; i++)
         fold_part = fold_part * TEN + frame_bytes[i] - ZERO_CH;
      frame_bytes[p] = sum_part - fold_part * TEN + ZERO_CH;
   endfunction

   // Build a frame of random content, well formed unless a flaw is asked for.
   task automatic build_frame(input int len, input frame_flaw_type flaw);
      int in_buf;
      int star_at;
      int shift;
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(8'($urandom));
      if (flaw == FLAW_NOISE) return;
      in_buf = (len < BUF_LEN) ? len : BUF_LEN;
      // cursor digits and the show flag, each half the time
      if (len > CURSOR_AT + 3) begin
         if ($urandom_range(0, 1)) begin
            for (int i = 0; i < 3; i++)
               frame_bytes[CURSOR_AT + i] = ZERO_CH + 8'($urandom_range(0, 9));
         end
         if ($urandom_range(0, 1)) frame_bytes[CURSOR_AT + 3] = ACTIVE_CH;
      end
      // address: a byte pair whose true value is zero, or a non-broadcast pair
      if (flaw == FLAW_ADDR) begin
         while ((int'(frame_bytes[ADDR_AT]) - 48) * 10 + int'(frame_bytes[ADDR_AT + 1]) - 48
                == 0)
            frame_bytes[ADDR_AT] = 8'($urandom);
      end else begin
         shift = $urandom_range(0, 8) - 4;
         frame_bytes[ADDR_AT]     = 8'(48 + shift);
         frame_bytes[ADDR_AT + 1] = 8'(48 - 10 * shift);
      end
      if (flaw == FLAW_NOSTAR) begin
         for (int i = 0; i < in_buf; i++)
            if (frame_bytes[i] == STAR_CH) frame_bytes[i] = frame_bytes[i] ^ 8'd1;
         return;
      end
      do star_at = $urandom_range(0, in_buf - 2);
      while (star_at == ADDR_AT || star_at == ADDR_AT + 1);
      for (int i = 0; i < star_at; i++)
         if (frame_bytes[i] == STAR_CH) frame_bytes[i] = frame_bytes[i] ^ 8'd1;
      frame_bytes[star_at] = STAR_CH;
      close_checksum(star_at, in_buf - 1);
      if (flaw == FLAW_SUM)
         frame_bytes[in_buf - 1] = frame_bytes[in_buf - 1] ^ 8'($urandom_range(1, 255));
   endtask

   function automatic int pick_len();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return $urandom_range(6, 24);
      if (pick < 8) return $urandom_range(25, CURSOR_AT + 3);
      return $urandom_range(CURSOR_AT + 4, 100);
   endfunction

   function automatic frame_flaw_type pick_flaw();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) return FLAW_NONE;
      if (pick < 14) return FLAW_ADDR;
      if (pick < 16) return FLAW_NOSTAR;
      if (pick < 19) return FLAW_SUM;
      return FLAW_NOISE;
   endfunction

   // Short hand-built frames: zero bytes, lone star, no star, wrapped address, odd broadcast.
   task automatic test_directed_frames();
      // zero bytes count as data; lines and cursor still hold their reset values
      frame_bytes = '{8'd0, 8'd0, 8'd0, ZERO_CH, ZERO_CH, STAR_CH, 8'd0};
      close_checksum(5, 6);
      send_frame();
      // star alone: sum 42 against nothing folded
      frame_bytes = '{STAR_CH};
      send_frame();
      // no star at all
      frame_bytes = '{8'hFF};
      send_frame();
      // address 256 would wrap to zero in 8 bits but must be rejected
      frame_bytes = '{8'hFF, 8'h00, STAR_CH, 8'd73, 8'd54, 8'd0, 8'd0};
      close_checksum(2, 6);
      send_frame();
      // broadcast from a non-digit pair: (49-48)*10 + 38-48 = 0
      frame_bytes = '{8'h80, 8'h7F, 8'h01, 8'd49, 8'd38, STAR_CH, 8'd0};
      close_checksum(5, 6);
      send_frame();
   endtask

   // Mostly well-formed frames of random content, one full layout and one overlong.
   task automatic test_random_frames();
      int target;
      target = items_sent + 240;
      build_frame($urandom_range(CURSOR_AT + 4, 90), FLAW_NONE);
      send_frame();
      build_frame($urandom_range(BUF_LEN + 1, BUF_LEN + 6), FLAW_NONE);
      send_frame();
      while (items_sent < target) begin
         build_frame(pick_len(), pick_flaw());
         send_frame();
      end
   endtask

   // Hold the receiver off long enough that the block stalls the next final byte.
   task automatic test_output_stall();
      sink_hold_cycles = 300;
      repeat (4) begin
         build_frame($urandom_range(6, 24), FLAW_NONE);
         send_frame();
      end
   endtask

   // Let the block drain completely between frames.
   task automatic test_sender_pause();
      repeat (3) begin
         wait_results();
         build_frame($urandom_range(6, 24), pick_flaw());
         send_frame();
      end
   endtask

   // Run back to back with no idling on either side.
   task automatic test_no_idle();
      int target;
      wait_results();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      target = items_sent + 40;
      while (items_sent < target) begin
         build_frame($urandom_range(6, 24), FLAW_NONE);
         send_frame();
      end
   endtask

   // Drive the result ready: long holds on request, random stall bursts otherwise.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            sink_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (sink_idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
         end
      end
   end

   // Compare each accepted item with the oldest prediction, field by field.
   task automatic check_display_item();
      result_type want;
      logic [7:0] got_f  [8];
      logic [7:0] want_f [8];
      if (display_items_due.size() == 0) begin
         $display("%0t ns: unexpected item, expected none, actual tuser=%h tdata=%h tlast=%b",
                  $time, rsp_tuser, rsp_tdata, rsp_tlast);
         mismatch_count++;
      end else begin
         want = display_items_due.pop_front();
         got_f[0]  = 8'(rsp_tuser);
         got_f[1]  = 8'(rsp_tdata[0]);
         got_f[2]  = 8'(rsp_tdata[4:1]);
         got_f[3]  = rsp_tdata[12:5];
         got_f[4]  = rsp_tdata[20:13];
         got_f[5]  = rsp_tdata[28:21];
         got_f[6]  = 8'(rsp_tdata[29]);
         got_f[7]  = 8'(rsp_tlast);
         want_f[0] = 8'(want.kind);
         want_f[1] = 8'(want.line);
         want_f[2] = 8'(want.column);
         want_f[3] = want.character;
         want_f[4] = want.cursor_row;
         want_f[5] = want.cursor_col;
         want_f[6] = 8'(want.cursor_on);
         want_f[7] = 8'(want.last);
         for (int i = 0; i < 8; i++) begin
            if (got_f[i] !== want_f[i]) begin
               $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                        $time, item_field[i], want_f[i], got_f[i]);
               mismatch_count++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_display_item();
   end

   // Bound the run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_random_frames();
      test_output_stall();
      test_sender_pause();
      test_no_idle();

      wait_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && display_items_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
